FILE: rtl/cce_pkg.sv
// cce_pkg: word types and register indexes for the crc codeword encoder
`default_nettype none

package cce_pkg;

    localparam int MAX_GEN_LEN = 16;
    localparam int GEN_CAP     = (MAX_GEN_LEN < 16) ? MAX_GEN_LEN : 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MODE = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [37:0] codeword_bits;
        logic [5:0]  codeword_len;
        logic [3:0]  pad_len;
        logic        stream_end;
    } t_out_word;

endpackage

`default_nettype wire

FILE: rtl/cce_encode.sv
// cce_encode: modulo-2 division of one byte or two nibbles and codeword assembly
`default_nettype none

module cce_encode (
    input  wire logic [7:0]  i_data,
    input  wire logic        i_nibble_mode,
    input  wire logic [15:0] i_gen_bits,
    input  wire logic [3:0]  i_rem_len,
    output logic      [37:0] o_codeword,
    output logic      [5:0]  o_len
);
    import cce_pkg::*;

    function automatic logic [22:0] enc_word(
        input logic [7:0]  data,
        input logic        dlen8,
        input logic [15:0] gen,
        input logic [3:0]  r
    );
        logic [23:0] base;
        logic [23:0] div;
        logic [23:0] mask;
        logic [23:0] res;
        base = {16'b0, data} << r;
        div  = base;
        mask = (24'd1 << r) - 24'd1;
        for (int i = 7; i >= 0; i--) begin
            if ((dlen8 || (i < 4)) && div[i + int'(r)]) begin
                div = div ^ ({8'b0, gen} << i);
            end
        end
        res = base | (div & mask);
        return res[22:0];
    endfunction

    logic [16:0] gen_mask;
    logic [4:0]  gen_len;
    logic [15:0] gen_used;
    logic [22:0] w_byte;
    logic [22:0] w_hi;
    logic [22:0] w_lo;
    logic [4:0]  half;
    logic [37:0] cw_nib;

    assign gen_len  = {1'b0, i_rem_len} + 5'd1;
    assign gen_mask = (17'd1 << gen_len) - 17'd1;
    assign gen_used = i_gen_bits & gen_mask[15:0];

    assign w_byte = enc_word(i_data, 1'b1, gen_used, i_rem_len);
    assign w_hi   = enc_word({4'b0, i_data[7:4]}, 1'b0, gen_used, i_rem_len);
    assign w_lo   = enc_word({4'b0, i_data[3:0]}, 1'b0, gen_used, i_rem_len);
    assign half   = {1'b0, i_rem_len} + 5'd4;
    assign cw_nib = ({19'b0, w_hi[18:0]} << half) | {19'b0, w_lo[18:0]};

    always_comb begin
        if (i_nibble_mode) begin
            o_codeword = cw_nib;
            o_len      = {half, 1'b0};
        end else begin
            o_codeword = {15'b0, w_byte};
            o_len      = {2'b0, i_rem_len} + 6'd8;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc_codeword_encoder.sv
// crc_codeword_encoder: top level with config registers, input and result stages
// result path: input register r_s1_word, then result register r_out_word; a result-side stall holds both
// throughput: one word per cycle while i_ready is high; the whole division is one combinational pass
// reset: synchronous active low; clears both stage valids and the bit count,
// and loads generator_bits 3, generator_len 2, nibble_mode 0
`default_nettype none

module crc_codeword_encoder (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire cce_pkg::t_in_word     i_word,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output cce_pkg::t_out_word         o_word
);
    import cce_pkg::*;

    logic [15:0] r_gen_bits;
    logic [4:0]  r_gen_len;
    logic        r_nibble_mode;
    logic [3:0]  r_bit_count;
    logic [3:0]  n_bit_count;
    logic        r_s1_valid;
    t_in_word    r_s1_word;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    logic        adv_out;
    logic [4:0]  eff_len;
    logic [3:0]  rem_len;
    logic [37:0] cw;
    logic [5:0]  cw_len;
    logic [3:0]  sum_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_bits    <= 16'd3;
            r_gen_len     <= 5'd2;
            r_nibble_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GEN_BITS:    r_gen_bits    <= i_cfg_data;
                CFG_GEN_LEN:     r_gen_len     <= i_cfg_data[4:0];
                CFG_NIBBLE_MODE: r_nibble_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_gen_len == 5'd0) begin
            eff_len = 5'd1;
        end else if (r_gen_len > 5'(GEN_CAP)) begin
            eff_len = 5'(GEN_CAP);
        end else begin
            eff_len = r_gen_len;
        end
    end
    assign rem_len = 4'(eff_len - 5'd1);

    assign adv_out = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_word <= i_word;
        end
    end

    cce_encode u_encode (
        .i_data        (r_s1_word.data_byte),
        .i_nibble_mode (r_nibble_mode),
        .i_gen_bits    (r_gen_bits),
        .i_rem_len     (rem_len),
        .o_codeword    (cw),
        .o_len         (cw_len)
    );

    // running bit count and pad on the last word
    always_comb begin
        sum_count                = r_bit_count + cw_len[3:0];
        n_out_word.codeword_bits = cw;
        n_out_word.codeword_len  = cw_len;
        n_out_word.stream_end    = r_s1_word.last_byte;
        if (r_s1_word.last_byte) begin
            n_out_word.pad_len = 4'd0 - sum_count;
            n_bit_count        = 4'd0;
        end else begin
            n_out_word.pad_len = 4'd0;
            n_bit_count        = sum_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bit_count <= 4'd0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_bit_count <= n_bit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking testbench for crc_codeword_encoder against a codeword scoreboard
`timescale 1ns / 1ps

import cce_pkg::*;

class codeword_scoreboard;
    logic [15:0] gen_bits;
    logic [4:0]  gen_len;
    logic        nibble_mode;
    logic [3:0]  bit_count;
    t_out_word   codeword_q[$];
    int          errors;

    function new();
        gen_bits    = 16'd3;
        gen_len     = 5'd2;
        nibble_mode = 1'b0;
        bit_count   = 4'd0;
        errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_GEN_BITS:    gen_bits    = val;
            CFG_GEN_LEN:     gen_len     = val[4:0];
            CFG_NIBBLE_MODE: nibble_mode = val[0];
            default: ;
        endcase
    endfunction

    // dataword followed by the modulo-2 remainder against the generator
    function logic [37:0] crc_codeword(logic [7:0] data, int dlen, int glen);
        int          r;
        logic [63:0] gen;
        logic [63:0] rem;
        r   = glen - 1;
        gen = 64'(gen_bits) & ((64'd1 << glen) - 64'd1);
        rem = 64'(data) << r;
        for (int i = dlen - 1; i >= 0; i--) begin
            if (rem[i + r]) rem = rem ^ (gen << i);
        end
        return 38'((64'(data) << r) | (rem & ((64'd1 << r) - 64'd1)));
    endfunction

    function void note_input(t_in_word w);
        int          glen;
        int          half;
        int          len;
        logic [63:0] cw;
        t_out_word   e;
        glen = int'(gen_len);
        if (glen < 1) glen = 1;
        if (glen > GEN_CAP) glen = GEN_CAP;
        if (nibble_mode) begin
            half = 4 + glen - 1;
            cw   = (64'(crc_codeword({4'd0, w.data_byte[7:4]}, 4, glen)) << half)
                 | 64'(crc_codeword({4'd0, w.data_byte[3:0]}, 4, glen));
            len  = 2 * half;
        end else begin
            cw  = 64'(crc_codeword(w.data_byte, 8, glen));
            len = 8 + glen - 1;
        end
        bit_count       = bit_count + 4'(len);
        e.codeword_bits = cw[37:0];
        e.codeword_len  = 6'(len);
        e.pad_len       = 4'd0;
        e.stream_end    = w.last_byte;
        if (w.last_byte) begin
            e.pad_len = 4'(16 - int'(bit_count));
            bit_count = 4'd0;
        end
        codeword_q.push_back(e);
    endfunction

    function void check_result(t_out_word got);
        t_out_word e;
        if (codeword_q.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, got);
            errors++;
            return;
        end
        e = codeword_q.pop_front();
        if (got.codeword_bits !== e.codeword_bits) begin
            $display("%0t codeword_bits: expected %h, actual %h", $time,
                     e.codeword_bits, got.codeword_bits);
            errors++;
        end
        if (got.codeword_len !== e.codeword_len) begin
            $display("%0t codeword_len: expected %0d, actual %0d", $time,
                     e.codeword_len, got.codeword_len);
            errors++;
        end
        if (got.pad_len !== e.pad_len) begin
            $display("%0t pad_len: expected %0d, actual %0d", $time, e.pad_len, got.pad_len);
            errors++;
        end
        if (got.stream_end !== e.stream_end) begin
            $display("%0t stream_end: expected %b, actual %b", $time,
                     e.stream_end, got.stream_end);
            errors++;
        end
    endfunction

    function int pending();
        return codeword_q.size();
    endfunction
endclass

module tb;
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_GEN_BITS;
    logic [15:0] cfg_data  = 16'd0;
    logic        in_valid  = 1'b0;
    t_in_word    in_word   = '0;
    logic        out_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    t_out_word   o_word;

    logic        idle_on    = 1'b1;
    int          stall_left = 0;
    logic [7:0]  dir_bytes[$];

    codeword_scoreboard sb = new();

    crc_codeword_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_ready    (o_ready),
        .i_word     (in_word),
        .o_valid    (o_valid),
        .i_ready    (out_ready),
        .o_word     (o_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall bursts, check every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && out_ready) sb.check_result(o_word);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] data, input logic last);
        t_in_word w;
        w.data_byte = data;
        w.last_byte = last;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] gbits, input logic [15:0] glen,
                                input logic [15:0] mode);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GEN_BITS;
        cfg_data <= gbits;
        @(posedge i_clk);
        sb.write_reg(CFG_GEN_BITS, gbits);
        cfg_idx  <= CFG_GEN_LEN;
        cfg_data <= glen;
        @(posedge i_clk);
        sb.write_reg(CFG_GEN_LEN, glen);
        cfg_idx  <= CFG_NIBBLE_MODE;
        cfg_data <= mode;
        @(posedge i_clk);
        sb.write_reg(CFG_NIBBLE_MODE, mode);
        cfg_we <= 1'b0;
    endtask

    task automatic send_directed();
        foreach (dir_bytes[k]) send_word(dir_bytes[k], k == dir_bytes.size() - 1);
        drain();
    endtask

    initial begin
        int          n;
        logic [15:0] glen;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config
        dir_bytes = {8'h00, 8'hff, 8'h80, 8'h01};
        send_directed();
        // zero length generator, empty remainder
        program_regs(16'h1234, 16'h0000, 16'h0001);
        dir_bytes = {8'ha5, 8'h5a};
        send_directed();
        // length above max saturates
        program_regs(16'hffff, 16'hffff, 16'hfffe);
        dir_bytes = {8'hff, 8'h00, 8'h7e};
        send_directed();
        // full length generator with lead bit zero
        program_regs(16'h1021, 16'h0010, 16'h0000);
        dir_bytes = {8'hff, 8'h01, 8'h80};
        send_directed();
        program_regs(16'h0000, 16'hffe1, 16'h0000);
        dir_bytes = {8'h55, 8'haa};
        send_directed();
        program_regs(16'h8005, 16'h0011, 16'h0000);
        dir_bytes = {8'hc3, 8'h3c};
        send_directed();
        program_regs(16'h0003, 16'h0004, 16'h0001);
        dir_bytes = {8'hf0, 8'h0f};
        send_directed();

        for (int p = 0; p < 9; p++) begin
            if (p == 8) idle_on <= 1'b0;
            case ($urandom_range(0, 7))
                0:       glen = 16'($urandom_range(17, 31));
                1:       glen = 16'd0;
                default: glen = 16'($urandom_range(1, 16));
            endcase
            glen[15:5] = 11'($urandom);
            program_regs(16'($urandom), glen, 16'($urandom));
            n = 80;
            for (int k = 0; k < n; k++) begin
                send_word(8'($urandom), $urandom_range(0, 7) == 0);
                // hold off the sender until the block is empty
                if (p == 3 && k == n / 2) drain();
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("crc_codeword_encoder regression: pass");
        end else begin
            $display("crc_codeword_encoder regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("crc_codeword_encoder regression: fail");
        $finish;
    end
endmodule
